>>> rtl/core/ldpg_pkg.sv
// Package for the line dash pattern generator.
// Holds the item action codes, result status codes and the control FSM states.
// No dependencies.
`timescale 1ns / 1ps

package ldpg_pkg;

  // Width of the start phase register and of the seg_length port
  localparam int PHASE_W   = 16;
  localparam int SEG_LEN_W = 16;
  // Bit counter for the restart divider, one dividend bit per cycle
  localparam int BIT_CNT_W = $clog2(PHASE_W);

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_TICK    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_NO_PATTERN = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SRCH_RD,
    S_SRCH_CMP
  } state_t;

endpackage

>>> rtl/core/line_dash_pattern_generator.sv
// Line dash pattern generator: top level with segment end memory and control.
// Depends on ldpg_pkg.
//
//   channel   | handshake              | payload
//   ----------+------------------------+--------------------------
//   command   | start / busy           | action, seg_length
//   result    | done (one-cycle pulse) | pen_on, status
//   config    | cfg_valid / cfg_ready  | cfg_data (start_phase)
//
// A new item is taken every cycle while busy is low, and the result of a
// clear, append or tick pulses on done the cycle after. The end of the
// current segment is prefetched from the segment memory, so ticks run
// back to back. A restart with a nonempty pattern holds busy through the
// bit-serial modulo (S_DIV) and then a read state and a compare state
// (S_SRCH_RD, S_SRCH_CMP) for each segment scanned in the memory. Reset
// is synchronous; the segment memory needs no clearing. The receiver
// cannot stall results.
`timescale 1ns / 1ps

module line_dash_pattern_generator #(
  parameter int MAX_SEGMENTS = 16,
  parameter int LENGTH_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    action,
  input  logic [ldpg_pkg::SEG_LEN_W-1:0] seg_length,
  // result channel
  output logic                          done,
  output logic                          pen_on,
  output logic [1:0]                    status,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ldpg_pkg::PHASE_W-1:0]  cfg_data
);

  import ldpg_pkg::*;

  // Effective segment length width, end position and counter widths
  localparam int LEN_W = (LENGTH_BITS < SEG_LEN_W) ? LENGTH_BITS : SEG_LEN_W;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int END_W = LENGTH_BITS + CNT_W;
  localparam int POS_W = END_W + 1;

  // Segment end memory
  logic [END_W-1:0] seg_mem [MAX_SEGMENTS];
  logic             mem_we;
  logic [IDX_W-1:0] wr_addr;
  logic [END_W-1:0] wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic [END_W-1:0] rd_data;

  // Control and pattern state
  state_t           state, state_next;
  logic [CNT_W-1:0] seg_count, seg_count_next;
  logic [IDX_W-1:0] cur_seg, cur_seg_next;
  logic [POS_W-1:0] pix_pos, pix_pos_next;
  logic             pen, pen_next;
  logic             pat_valid, pat_valid_next;
  logic [END_W-1:0] total, total_next;
  logic [PHASE_W-1:0] start_phase;
  // Restart divider and search
  logic [BIT_CNT_W-1:0] div_bit, div_bit_next;
  logic [END_W-1:0]     rem, rem_next;
  logic [IDX_W-1:0]     srch_idx, srch_idx_next;
  // Result register
  logic             done_next, pen_on_next;
  logic [1:0]       status_next;

  // Datapath helpers
  logic             accept;
  logic [END_W:0]   div_shift;
  logic             div_ge;
  logic             pos_hit;
  logic             last_seg;
  logic [POS_W-1:0] pos_wrap;
  logic [CNT_W-1:0] cnt_last;
  logic             tick_ok;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;

  assign cnt_last  = seg_count - CNT_W'(1);
  assign last_seg  = (CNT_W'(cur_seg) == cnt_last);
  assign pos_hit   = (pix_pos >= POS_W'(rd_data));
  assign pos_wrap  = pix_pos - POS_W'(rd_data);
  assign tick_ok   = pat_valid && (seg_count != '0) && (CNT_W'(cur_seg) < seg_count);

  // One restoring division step: shift in the next dividend bit
  assign div_shift = {rem, start_phase[div_bit]};
  assign div_ge    = (div_shift >= {1'b0, total});

  // Next state, datapath updates and result
  always_comb begin
    state_next     = state;
    seg_count_next = seg_count;
    cur_seg_next   = cur_seg;
    pix_pos_next   = pix_pos;
    pen_next       = pen;
    pat_valid_next = pat_valid;
    total_next     = total;
    div_bit_next   = div_bit;
    rem_next       = rem;
    srch_idx_next  = srch_idx;
    done_next      = 1'b0;
    pen_on_next    = pen_on;
    status_next    = status;
    mem_we         = 1'b0;
    wr_addr        = seg_count[IDX_W-1:0];
    wr_data        = END_W'(total + END_W'(seg_length[LEN_W-1:0]));

    case (state)
      S_IDLE: begin
        if (accept) begin
          done_next   = 1'b1;
          status_next = ST_OK;
          case (action)
            ACT_CLEAR: begin
              seg_count_next = '0;
              cur_seg_next   = '0;
              pix_pos_next   = '0;
              pen_next       = 1'b1;
              pat_valid_next = 1'b0;
              total_next     = '0;
              pen_on_next    = 1'b1;
            end
            ACT_APPEND: begin
              pen_on_next = pen;
              if (seg_count >= CNT_W'(MAX_SEGMENTS)) begin
                status_next = ST_FULL;
              end else begin
                mem_we         = 1'b1;
                total_next     = wr_data;
                seg_count_next = seg_count + CNT_W'(1);
                pat_valid_next = 1'b0;
              end
            end
            ACT_RESTART: begin
              pen_next = 1'b1;
              if (total == '0) begin
                pat_valid_next = 1'b0;
                pen_on_next    = 1'b1;
                status_next    = ST_NO_PATTERN;
              end else begin
                // result comes when the search finishes
                done_next    = 1'b0;
                rem_next     = '0;
                div_bit_next = BIT_CNT_W'(PHASE_W - 1);
                state_next   = S_DIV;
              end
            end
            ACT_TICK: begin
              if (!tick_ok) begin
                pen_on_next = 1'b1;
                status_next = ST_NO_PATTERN;
              end else begin
                pix_pos_next = pix_pos + POS_W'(1);
                if (pos_hit) begin
                  pen_next = !pen;
                  if (last_seg) begin
                    cur_seg_next = '0;
                    pix_pos_next = pos_wrap + POS_W'(1);
                  end else begin
                    cur_seg_next = cur_seg + IDX_W'(1);
                  end
                end
                pen_on_next = pen_next;
              end
            end
            default: begin
              status_next = ST_OK;
            end
          endcase
        end
      end
      S_DIV: begin
        rem_next = div_ge ? END_W'(div_shift - {1'b0, total}) : END_W'(div_shift);
        div_bit_next = div_bit - BIT_CNT_W'(1);
        if (div_bit == '0) begin
          srch_idx_next = '0;
          state_next    = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        state_next = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        // first segment whose end is not below the phase
        if ((rem > rd_data) && (CNT_W'(srch_idx) != cnt_last)) begin
          srch_idx_next = srch_idx + IDX_W'(1);
          state_next    = S_SRCH_RD;
        end else begin
          cur_seg_next   = srch_idx;
          pix_pos_next   = POS_W'(rem);
          pat_valid_next = 1'b1;
          done_next      = 1'b1;
          pen_on_next    = 1'b1;
          status_next    = ST_OK;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Read address: prefetch the end of the segment that will be current, or the segment under test while searching
  always_comb begin
    rd_addr = cur_seg_next;
    if (state == S_SRCH_RD) begin
      rd_addr = srch_idx;
    end
  end

  // Segment end memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      seg_mem[wr_addr] <= wr_data;
    end
    rd_data <= seg_mem[rd_addr];
  end

  // Control state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      seg_count   <= '0;
      cur_seg     <= '0;
      pix_pos     <= '0;
      pen         <= 1'b1;
      pat_valid   <= 1'b0;
      total       <= '0;
      start_phase <= '0;
      done        <= 1'b0;
    end else begin
      state     <= state_next;
      seg_count <= seg_count_next;
      cur_seg   <= cur_seg_next;
      pix_pos   <= pix_pos_next;
      pen       <= pen_next;
      pat_valid <= pat_valid_next;
      total     <= total_next;
      done      <= done_next;
      if (cfg_valid && cfg_ready) begin
        start_phase <= cfg_data;
      end
    end
  end

  // Divider, search and result payload registers
  always_ff @(posedge clk) begin
    div_bit  <= div_bit_next;
    rem      <= rem_next;
    srch_idx <= srch_idx_next;
    pen_on   <= pen_on_next;
    status   <= status_next;
  end

endmodule

>>> rtl/core/ldpg_checker.sv
// Port-level checks for the line dash pattern generator, bound to the top level.
// Depends on ldpg_pkg and line_dash_pattern_generator.
`timescale 1ns / 1ps

module ldpg_assertions (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] action,
  input logic       done,
  input logic       pen_on,
  input logic [1:0] status
);

  import ldpg_pkg::*;

  // A result never shows while a restart is still in progress
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // Every item other than a restart gives its result in the next cycle
  a_fast_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (action != ACT_RESTART)) |=> done)
    else $error("missing result after single-cycle item");

  // A clear always answers pen on with status ok
  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (action == ACT_CLEAR)) |=>
      (pen_on && (status == ST_OK)))
    else $error("clear gave wrong result");

  // Only a restart item can make the block busy
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> ($past(start) && ($past(action) == ACT_RESTART)))
    else $error("busy without a restart item");

  // Status code stays within its defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status != 2'd3))
    else $error("undefined status code");

endmodule

bind line_dash_pattern_generator ldpg_assertions u_ldpg_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .action (action),
  .done   (done),
  .pen_on (pen_on),
  .status (status)
);

>>> tb/ldpg_checker.sv
// Result checker for the line dash pattern generator testbench.
// Watches the command, result and config channels, predicts pen_on/status per item.
// Depends on ldpg_pkg.
`timescale 1ns / 1ps

module ldpg_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [1:0]                    action,
  input  logic [ldpg_pkg::SEG_LEN_W-1:0] seg_length,
  input  logic                          done,
  input  logic                          pen_on,
  input  logic [1:0]                    status,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [ldpg_pkg::PHASE_W-1:0]  cfg_data,
  output int                            mismatch_count,
  output int                            outstanding
);

  import ldpg_pkg::*;

  localparam int TABLE_DEPTH = 16;

  typedef struct packed {
    logic    pen;
    status_t st;
  } dash_result_t;

  // Shadow copy of the pattern state
  logic [19:0]        seg_end_tbl [TABLE_DEPTH];
  logic [4:0]         seg_cnt;
  logic [3:0]         cur_seg;
  logic [20:0]        pix_pos;
  logic               pen_q;
  logic               pattern_ok;
  logic [PHASE_W-1:0] phase_reg;

  dash_result_t pending_pen_q[$];

  assign outstanding = pending_pen_q.size();

  // Apply one item to the shadow state and return the pen/status it should produce
  function automatic dash_result_t predict_dash(action_t act, logic [SEG_LEN_W-1:0] len);
    int unsigned total;
    int unsigned ph;
    int unsigned idx;
    logic [19:0] prev_end;
    logic [19:0] seg_end;
    status_t     st;
    st = ST_OK;
    case (act)
      ACT_CLEAR: begin
        seg_cnt    = '0;
        cur_seg    = '0;
        pix_pos    = '0;
        pen_q      = 1'b1;
        pattern_ok = 1'b0;
      end
      ACT_APPEND: begin
        if (seg_cnt >= TABLE_DEPTH) begin
          st = ST_FULL;
        end else begin
          prev_end = (seg_cnt != 0) ? seg_end_tbl[seg_cnt - 1] : 20'd0;
          seg_end_tbl[seg_cnt] = prev_end + len;
          seg_cnt    = seg_cnt + 5'd1;
          pattern_ok = 1'b0;
        end
      end
      ACT_RESTART: begin
        total = (seg_cnt != 0) ? seg_end_tbl[seg_cnt - 1] : 0;
        pen_q = 1'b1;
        if (total == 0) begin
          pattern_ok = 1'b0;
          st = ST_NO_PATTERN;
        end else begin
          ph  = phase_reg % total;
          idx = 0;
          // first segment whose end is not below the phase
          while (idx < seg_cnt && ph > seg_end_tbl[idx]) idx++;
          if (idx >= seg_cnt) idx = seg_cnt - 1;
          cur_seg    = idx[3:0];
          pix_pos    = ph[20:0];
          pattern_ok = 1'b1;
        end
      end
      default: begin
        // tick
        if (!pattern_ok || seg_cnt == 0 || cur_seg >= seg_cnt) begin
          return '{pen: 1'b1, st: ST_NO_PATTERN};
        end
        seg_end = seg_end_tbl[cur_seg];
        if (pix_pos >= seg_end) begin
          pen_q = ~pen_q;
          if (cur_seg == seg_cnt - 1) begin
            cur_seg = '0;
            pix_pos = pix_pos - seg_end;
          end else begin
            cur_seg = cur_seg + 4'd1;
          end
        end
        pix_pos = pix_pos + 21'd1;
      end
    endcase
    return '{pen: pen_q, st: st};
  endfunction

  // Compare results first, then record the item taken at this edge
  always @(posedge clk) begin
    dash_result_t want;
    if (rst) begin
      seg_cnt        = '0;
      cur_seg        = '0;
      pix_pos        = '0;
      pen_q          = 1'b1;
      pattern_ok     = 1'b0;
      phase_reg      = '0;
      mismatch_count = 0;
      pending_pen_q.delete();
    end else begin
      if (done) begin
        if (pending_pen_q.size() == 0) begin
          $error("result pulse with no item outstanding (pen_on=%0d status=%0d)",
                 pen_on, status);
          mismatch_count++;
        end else begin
          want = pending_pen_q.pop_front();
          if (pen_on !== want.pen) begin
            $error("pen_on mismatch: expected %0d, got %0d", want.pen, pen_on);
            mismatch_count++;
          end
          if (status !== want.st) begin
            $error("status mismatch: expected %0d, got %0d", want.st, status);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) phase_reg = cfg_data;
      if (start && !busy) pending_pen_q.push_back(predict_dash(action_t'(action), seg_length));
    end
  end

endmodule

>>> tb/tb_line_dash_pattern_generator.sv
// Top of the line dash pattern generator testbench: clock, reset, stimulus, verdict.
// Depends on ldpg_pkg, line_dash_pattern_generator and ldpg_checker.
`timescale 1ns / 1ps

module tb_line_dash_pattern_generator;
  import ldpg_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int ITEMS_PER_PH = 315;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           action = ACT_CLEAR;
  logic [SEG_LEN_W-1:0] seg_length = '0;
  logic                 done;
  logic                 pen_on;
  logic [1:0]           status;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [PHASE_W-1:0]   cfg_data = '0;

  int mismatch_count;
  int outstanding;
  int items_sent = 0;
  int idle_cycles = 0;
  bit gaps_on = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  line_dash_pattern_generator i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .seg_length (seg_length),
    .done       (done),
    .pen_on     (pen_on),
    .status     (status),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  ldpg_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .seg_length     (seg_length),
    .done           (done),
    .pen_on         (pen_on),
    .status         (status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  // Watchdog: no handshake of any kind for too long ends the run
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Hand one item to the block, with optional random gaps before it
  task automatic drive_item(input action_t act, input logic [SEG_LEN_W-1:0] len);
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 35) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start      <= 1'b1;
    action     <= act;
    seg_length <= len;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // Hold off until every outstanding result has come back
  task automatic wait_drained(input int extra);
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_start_phase(input logic [PHASE_W-1:0] value);
    wait_drained(DRAIN_CYCLES);
    if (gaps_on) repeat ($urandom_range(0, 3)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly short segments so ticks wrap often, with the odd extreme
  function automatic logic [SEG_LEN_W-1:0] pick_len();
    int r;
    r = $urandom_range(0, 15);
    case (r)
      0:       return '0;
      1:       return '1;
      2:       return SEG_LEN_W'($urandom);
      3:       return SEG_LEN_W'($urandom_range(100, 3000));
      default: return SEG_LEN_W'($urandom_range(1, 8));
    endcase
  endfunction

  // One pattern: optional clear, appends, restart, a run of ticks;
  // some are broken (no clear, no restart, append mid-run) and some are noise
  task automatic run_pattern();
    int kind;
    int n_seg;
    int n_tick;
    int r;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      drive_item(action_t'($urandom_range(0, 3)), SEG_LEN_W'($urandom));
      return;
    end
    if ($urandom_range(0, 3) != 0) drive_item(ACT_CLEAR, SEG_LEN_W'($urandom));
    r = $urandom_range(0, 9);
    if (r < 7)      n_seg = $urandom_range(1, 4);
    else if (r < 9) n_seg = $urandom_range(5, 16);
    else            n_seg = $urandom_range(17, 20);
    repeat (n_seg) drive_item(ACT_APPEND, pick_len());
    if (kind != 2) drive_item(ACT_RESTART, SEG_LEN_W'($urandom));
    n_tick = $urandom_range(1, 48);
    repeat (n_tick) drive_item(ACT_TICK, SEG_LEN_W'($urandom));
    if (kind == 3) begin
      // append invalidates until the next restart
      drive_item(ACT_APPEND, pick_len());
      repeat ($urandom_range(1, 3)) drive_item(ACT_TICK, SEG_LEN_W'($urandom));
      drive_item(ACT_RESTART, SEG_LEN_W'($urandom));
      repeat ($urandom_range(1, 24)) drive_item(ACT_TICK, SEG_LEN_W'($urandom));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: no pattern, zero total, short pattern wrap, invalidate, phase search
    drive_item(ACT_TICK, '0);
    drive_item(ACT_RESTART, '1);
    drive_item(ACT_APPEND, '0);
    drive_item(ACT_RESTART, '0);
    drive_item(ACT_TICK, '1);
    drive_item(ACT_CLEAR, '1);
    drive_item(ACT_APPEND, 16'd2);
    drive_item(ACT_APPEND, 16'd3);
    drive_item(ACT_RESTART, '0);
    repeat (7) drive_item(ACT_TICK, '0);
    drive_item(ACT_APPEND, '1);
    drive_item(ACT_TICK, '0);
    write_start_phase(16'd7);
    drive_item(ACT_RESTART, '0);
    repeat (3) drive_item(ACT_TICK, '1);
    drive_item(ACT_CLEAR, '0);
    drive_item(ACT_TICK, '0);

    // Random phases, each under its own start phase
    for (int p = 0; p < 6; p++) begin
      gaps_on = (p != 2);
      case (p)
        0:       write_start_phase('1);
        1:       write_start_phase(16'd1);
        2:       write_start_phase('0);
        4:       write_start_phase(16'h8000);
        default: write_start_phase(PHASE_W'($urandom));
      endcase
      if (p == 0) begin
        // largest segments into a full table; a rejected append keeps the pattern live
        drive_item(ACT_CLEAR, '0);
        repeat (17) drive_item(ACT_APPEND, '1);
        drive_item(ACT_RESTART, '0);
        repeat (4) drive_item(ACT_TICK, '0);
        drive_item(ACT_APPEND, 16'd5);
        repeat (4) drive_item(ACT_TICK, '0);
      end
      while (items_sent < 24 + (p + 1) * ITEMS_PER_PH) begin
        run_pattern();
        if ($urandom_range(0, 49) == 0) wait_drained(0);
      end
    end

    wait_drained(10);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
